>>> rtl/bdpc_pkg.sv
package bdpc_pkg;

  // Width of the tick-count configuration registers and of the write data bus
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG     = 2'd2;

  // Reset values of the configuration registers
  localparam logic             RST_ENABLE   = 1'b1;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd50;
  localparam logic [CFG_W-1:0] RST_LONG     = 16'd10000;

  // Released level of the active-low pin
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef struct packed {
    logic             button_enable;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } bdpc_cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held;
  } bdpc_result_t;

endpackage

>>> rtl/bdpc_classifier.sv
module bdpc_classifier #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                raw_level,
  input  bdpc_pkg::bdpc_cfg_t cfg,
  output bdpc_pkg::bdpc_result_t result
);
  import bdpc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic                   last_level_r, last_level_nxt;
  logic [COUNT_WIDTH-1:0] settle_count_r, settle_count_nxt;
  logic                   press_active_r, press_active_nxt;
  logic                   long_done_r, long_done_nxt;
  logic [COUNT_WIDTH-1:0] hold_count_r, hold_count_nxt;

  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] settle_inc;
  logic [CMP_W-1:0]       settle_ext, hold_ext, deb_ext, long_ext;
  logic                   settled;
  logic                   pressed;
  logic                   hold_long;
  logic                   short_p, long_p;

  // Saturating increments
  assign hold_inc   = (&hold_count_r) ? hold_count_r : hold_count_r + 1'b1;
  assign settle_inc = (&settle_count_r) ? settle_count_r : settle_count_r + 1'b1;

  assign deb_ext  = CMP_W'(cfg.debounce_ticks);
  assign long_ext = CMP_W'(cfg.long_press_ticks);
  assign pressed  = ~raw_level;

  // Next state and result for one tick
  always_comb begin
    last_level_nxt   = last_level_r;
    settle_count_nxt = settle_inc;
    press_active_nxt = press_active_r;
    long_done_nxt    = long_done_r;
    hold_count_nxt   = press_active_r ? hold_inc : hold_count_r;
    short_p          = 1'b0;
    long_p           = 1'b0;
    settled          = 1'b0;
    hold_long        = 1'b0;
    settle_ext       = '0;
    hold_ext         = '0;

    if (cfg.button_enable) begin
      // Restart the settle count on any level change
      if (raw_level != last_level_r) begin
        last_level_nxt   = raw_level;
        settle_count_nxt = '0;
      end
      settle_ext = CMP_W'(settle_count_nxt);
      settled    = settle_ext >= deb_ext;

      if (settled) begin
        // Open a press on a settled low level
        if (pressed && !press_active_r) begin
          press_active_nxt = 1'b1;
          long_done_nxt    = 1'b0;
          hold_count_nxt   = '0;
        end
        hold_ext  = CMP_W'(hold_count_nxt);
        hold_long = hold_ext >= long_ext;

        if (pressed && press_active_nxt && !long_done_nxt && hold_long) begin
          long_done_nxt = 1'b1;
          long_p        = 1'b1;
        end else if (!pressed && press_active_nxt) begin
          // Release: short unless the hold already counted as long
          short_p          = !(long_done_nxt || hold_long);
          press_active_nxt = 1'b0;
          long_done_nxt    = 1'b0;
        end
      end
    end
  end

  assign result.short_press = short_p;
  assign result.long_press  = long_p;
  assign result.held        = cfg.button_enable & press_active_nxt;

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= LEVEL_RELEASED;
      settle_count_r <= '0;
      press_active_r <= 1'b0;
      long_done_r    <= 1'b0;
      hold_count_r   <= '0;
    end else if (step) begin
      last_level_r   <= last_level_nxt;
      settle_count_r <= settle_count_nxt;
      press_active_r <= press_active_nxt;
      long_done_r    <= long_done_nxt;
      hold_count_r   <= hold_count_nxt;
    end
  end

endmodule

>>> rtl/button_debounce_press_classifier.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_raw_level (one tick)
// out_      output     out_valid / out_ready  out_short_press, out_long_press, out_held
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// One item per clock while the output register is drained: the classifier
// state and the result are computed in the accept cycle and registered on accept.
// in_ready is high whenever the output register is empty or being drained, so
// a stalled out_ready stops intake only while a result is waiting.
// Reset (rst_n low, synchronous) empties the output register, loads the
// register defaults and returns the pin history to released.
module button_debounce_press_classifier #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_raw_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_short_press,
  output logic                           out_long_press,
  output logic                           out_held,
  input  logic                           cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_W-1:0]     cfg_wdata
);
  import bdpc_pkg::*;

  bdpc_cfg_t    cfg_r;
  bdpc_result_t result;
  bdpc_result_t res_r;
  logic         out_valid_r;
  logic         in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_enable    <= RST_ENABLE;
      cfg_r.debounce_ticks   <= RST_DEBOUNCE;
      cfg_r.long_press_ticks <= RST_LONG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_ENABLE:   cfg_r.button_enable    <= cfg_wdata[0];
        CFG_IDX_DEBOUNCE: cfg_r.debounce_ticks   <= cfg_wdata;
        CFG_IDX_LONG:     cfg_r.long_press_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bdpc_classifier #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .raw_level (in_raw_level),
    .cfg       (cfg_r),
    .result    (result)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_short_press = res_r.short_press;
  assign out_long_press  = res_r.long_press;
  assign out_held        = res_r.held;

  // Checks
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_short_press && out_long_press))
    else $error("short and long press in the same item");

  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_long_press |-> out_held)
    else $error("long press reported without a held press");

  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_press |-> !out_held)
    else $error("short press reported while still held");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !cfg_r.button_enable |=>
      out_valid && !out_short_press && !out_long_press && !out_held)
    else $error("disabled block produced an event");

endmodule
